[hdl/tql_pkg.sv]
package tql_pkg;

   // table geometry
   localparam int NUM_STATES  = 64;
   localparam int NUM_ACTIONS = 8;
   localparam int TABLE_SIZE  = NUM_STATES * NUM_ACTIONS;
   localparam int ADDR_W      = $clog2(TABLE_SIZE);
   localparam int STATE_W     = $clog2(NUM_STATES);
   localparam int ACT_W       = $clog2(NUM_ACTIONS);
   localparam int CNT_W       = ADDR_W + 1;

   // field widths
   localparam int STATE_IN_W = 6;
   localparam int ACT_IN_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int TRACE_W    = 17;
   localparam int RATE_W     = 16;

   localparam logic [TRACE_W-1:0] TRACE_ONE = 17'h10000;

   // item functions
   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_EPISODE = 1'b1;

   // register indexes (word address bits)
   localparam logic [1:0] CSR_DISCOUNT    = 2'd0;
   localparam logic [1:0] CSR_TRACE_DECAY = 2'd1;
   localparam logic [1:0] CSR_LEARN_RATE  = 2'd2;
   localparam logic [1:0] CSR_BASELINE    = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_SWEEP,
      ST_DRAIN,
      ST_WIPE
   } state_type;

   typedef struct packed {
      logic                issue;
      logic [ADDR_W-1:0]   addr;
      logic [ADDR_W-1:0]   prev_addr;
      logic [VALUE_W-1:0]  td;
   } sweep_cmd_type;

   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   addr;
      logic [TRACE_W-1:0]  data;
   } trace_wr_type;

   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   addr;
      logic [VALUE_W-1:0]  data;
   } value_wr_type;

   // reduce a state index modulo the state count, one restoring step per bit
   function automatic logic [STATE_W-1:0] wrap_state(input logic [STATE_IN_W-1:0] x);
      logic [STATE_IN_W-1:0] r;
      r = x;
      for (int k = STATE_IN_W - 1; k >= 0; k--) begin
         if (int'(r) >= (NUM_STATES << k)) begin
            r = r - STATE_IN_W'(NUM_STATES << k);
         end
      end
      return STATE_W'(r);
   endfunction

   // reduce an action index modulo the action count
   function automatic logic [ACT_W-1:0] wrap_action(input logic [ACT_IN_W-1:0] x);
      logic [ACT_IN_W-1:0] r;
      r = x;
      for (int k = ACT_IN_W - 1; k >= 0; k--) begin
         if (int'(r) >= (NUM_ACTIONS << k)) begin
            r = r - ACT_IN_W'(NUM_ACTIONS << k);
         end
      end
      return ACT_W'(r);
   endfunction

   // flat table address of a state and action
   function automatic logic [ADDR_W-1:0] make_addr(input logic [STATE_W-1:0] s,
                                                   input logic [ACT_W-1:0] a);
      return ADDR_W'(s) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(a);
   endfunction

   // saturate a two's complement 36-bit value to 32 bits
   function automatic logic [VALUE_W-1:0] sat32(input logic [35:0] x);
      logic [VALUE_W-1:0] r;
      if (!x[35] && (x[34:31] != 4'h0)) begin
         r = 32'h7FFF_FFFF;
      end else if (x[35] && (x[34:31] != 4'hF)) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[hdl/tql_tables.sv]
module tql_tables (
   input  logic                         clock,
   input  logic [tql_pkg::ADDR_W-1:0]   rd_addr,
   output logic [tql_pkg::VALUE_W-1:0]  value_rd_data,
   output logic [tql_pkg::TRACE_W-1:0]  trace_rd_data,
   input  tql_pkg::value_wr_type        value_wr,
   input  tql_pkg::trace_wr_type        trace_wr
);
   import tql_pkg::*;

   logic [VALUE_W-1:0] value_mem [TABLE_SIZE];
   logic [TRACE_W-1:0] trace_mem [TABLE_SIZE];
   logic [VALUE_W-1:0] value_rd_ff;
   logic [TRACE_W-1:0] trace_rd_ff;

   // value table: one write, one registered read
   always_ff @(posedge clock) begin
      if (value_wr.we) begin
         value_mem[value_wr.addr] <= value_wr.data;
      end
      value_rd_ff <= value_mem[rd_addr];
   end

   // trace table: one write, one registered read
   always_ff @(posedge clock) begin
      if (trace_wr.we) begin
         trace_mem[trace_wr.addr] <= trace_wr.data;
      end
      trace_rd_ff <= trace_mem[rd_addr];
   end

   assign value_rd_data = value_rd_ff;
   assign trace_rd_data = trace_rd_ff;

endmodule

[hdl/tql_sweep.sv]
module tql_sweep (
   input  logic                         clock,
   input  logic                         reset,
   input  tql_pkg::sweep_cmd_type       cmd,
   input  logic [tql_pkg::RATE_W-1:0]   trace_decay,
   input  logic [tql_pkg::RATE_W-1:0]   learning_rate,
   input  logic [tql_pkg::TRACE_W-1:0]  trace_rd_data,
   input  logic [tql_pkg::VALUE_W-1:0]  value_rd_data,
   output tql_pkg::trace_wr_type        trace_wr,
   output tql_pkg::value_wr_type        value_wr,
   output logic                         pipe_busy
);
   import tql_pkg::*;

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic [ADDR_W-1:0]   addr1_ff, addr2_ff, addr3_ff, addr4_ff;
   logic [VALUE_W-1:0]  val2_ff, val3_ff, val4_ff;
   logic [TRACE_W-1:0]  trace2_ff, trace2_in;
   logic [TRACE_W-1:0]  step3_ff, step3_in;
   logic [33:0]         delta4_ff, delta4_in;
   logic [32:0]         t_prod, s_prod;
   logic signed [49:0]  step_x, td_x, d_prod;
   logic [35:0]         sum;

   // stage 1: decay the trace, or set it to one for the previous pair
   always_comb begin
      t_prod = 33'(trace_rd_data) * 33'(trace_decay);
      if (addr1_ff == cmd.prev_addr) begin
         trace2_in = TRACE_ONE;
      end else begin
         trace2_in = t_prod[32:16];
      end
   end

   // stage 2: scale the new trace by the step size
   always_comb begin
      s_prod   = 33'(trace2_ff) * 33'(learning_rate);
      step3_in = s_prod[32:16];
   end

   // stage 3: scale the step by the error, floor on the fraction
   always_comb begin
      step_x    = {33'b0, step3_ff};
      td_x      = {{18{cmd.td[VALUE_W-1]}}, cmd.td};
      d_prod    = step_x * td_x;
      delta4_in = d_prod[49:16];
   end

   // stage 4: add and saturate
   assign sum = {{4{val4_ff[VALUE_W-1]}}, val4_ff} + {{2{delta4_ff[33]}}, delta4_ff};

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      addr1_ff  <= cmd.addr;
      addr2_ff  <= addr1_ff;
      addr3_ff  <= addr2_ff;
      addr4_ff  <= addr3_ff;
      val2_ff   <= value_rd_data;
      val3_ff   <= val2_ff;
      val4_ff   <= val3_ff;
      trace2_ff <= trace2_in;
      step3_ff  <= step3_in;
      delta4_ff <= delta4_in;
   end

   assign trace_wr.we   = v2_ff;
   assign trace_wr.addr = addr2_ff;
   assign trace_wr.data = trace2_ff;

   assign value_wr.we   = v4_ff;
   assign value_wr.addr = addr4_ff;
   assign value_wr.data = sat32(sum);

   assign pipe_busy = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

[hdl/tql_ctrl.sv]
module tql_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            func,
   input  logic [tql_pkg::VALUE_W-1:0]     reward,
   input  logic [tql_pkg::STATE_IN_W-1:0]  dest_state,
   input  logic [tql_pkg::ACT_IN_W-1:0]    dest_action,
   input  logic [tql_pkg::RATE_W-1:0]      discount,
   input  logic [tql_pkg::VALUE_W-1:0]     reward_baseline,
   input  logic [tql_pkg::VALUE_W-1:0]     value_rd_data,
   input  logic                            pipe_busy,
   output logic [tql_pkg::ADDR_W-1:0]      rd_addr,
   output tql_pkg::sweep_cmd_type          sweep_cmd,
   output tql_pkg::value_wr_type           clr_value_wr,
   output tql_pkg::trace_wr_type           clr_trace_wr,
   output logic                            rsp_valid,
   output logic [tql_pkg::VALUE_W-1:0]     rsp_td
);
   import tql_pkg::*;

   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0] CNT_ACTS  = CNT_W'(NUM_ACTIONS);
   localparam logic [CNT_W-1:0] CALC_PROD = CNT_W'(1);
   localparam logic [CNT_W-1:0] CALC_LAST = CNT_W'(2);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                prev_valid_ff, prev_valid_in;
   logic [STATE_W-1:0]  prev_state_ff, prev_state_in;
   logic [ACT_W-1:0]    prev_action_ff, prev_action_in;
   logic [STATE_W-1:0]  ns_ff, ns_in;
   logic [ACT_W-1:0]    na_ff, na_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [VALUE_W-1:0]  reward_ff, reward_in;
   logic [VALUE_W-1:0]  best_ff, best_in;
   logic [VALUE_W-1:0]  qprev_ff, qprev_in;
   logic [48:0]         prod_ff, prod_in;
   logic [VALUE_W-1:0]  td_ff, td_in;
   logic                rd_live_ff;
   logic [CNT_W-1:0]    rd_idx_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_td_ff, rsp_td_in;
   logic                accept;
   logic [ADDR_W-1:0]   prev_addr;
   logic signed [48:0]  best_x, disc_x;
   logic [35:0]         diff;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign prev_addr = make_addr(prev_state_ff, prev_action_ff);

   // greedy value times discount, and the error against the previous entry
   always_comb begin
      best_x = {{17{best_ff[VALUE_W-1]}}, best_ff};
      disc_x = {33'b0, discount};
      diff   = {{4{reward_ff[VALUE_W-1]}}, reward_ff}
             - {{4{reward_baseline[VALUE_W-1]}}, reward_baseline}
             + {{3{prod_ff[48]}}, prod_ff[48:16]}
             - {{4{qprev_ff[VALUE_W-1]}}, qprev_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CNT_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (func == FUNC_EPISODE) begin
                  state_in = ST_WIPE;
               end else if (prev_valid_ff) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_ACTS) state_in = ST_CALC;
         end
         ST_CALC: begin
            if (cnt_ff == CALC_LAST) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (cnt_ff == CNT_LAST) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = ST_IDLE;
         end
         ST_WIPE: begin
            if (cnt_ff == CNT_LAST) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      cnt_in         = cnt_ff + CNT_W'(1);
      prev_valid_in  = prev_valid_ff;
      prev_state_in  = prev_state_ff;
      prev_action_in = prev_action_ff;
      ns_in          = ns_ff;
      na_in          = na_ff;
      base_in        = base_ff;
      reward_in      = reward_ff;
      best_in        = best_ff;
      qprev_in       = qprev_ff;
      prod_in        = prod_ff;
      td_in          = td_ff;
      rsp_valid_in   = 1'b0;
      rsp_td_in      = rsp_td_ff;
      rd_addr        = cnt_ff[ADDR_W-1:0];
      sweep_cmd.issue     = 1'b0;
      sweep_cmd.addr      = cnt_ff[ADDR_W-1:0];
      sweep_cmd.prev_addr = prev_addr;
      sweep_cmd.td        = td_ff;
      clr_value_wr.we   = 1'b0;
      clr_value_wr.addr = cnt_ff[ADDR_W-1:0];
      clr_value_wr.data = '0;
      clr_trace_wr.we   = 1'b0;
      clr_trace_wr.addr = cnt_ff[ADDR_W-1:0];
      clr_trace_wr.data = '0;

      // collect the scanned row and the previous entry
      if (rd_live_ff) begin
         if (rd_idx_ff == '0) begin
            best_in = value_rd_data;
         end else if (rd_idx_ff < CNT_ACTS) begin
            if ($signed(value_rd_data) > $signed(best_ff)) best_in = value_rd_data;
         end else begin
            qprev_in = value_rd_data;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_value_wr.we = 1'b1;
            clr_trace_wr.we = 1'b1;
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               ns_in     = wrap_state(dest_state);
               na_in     = wrap_action(dest_action);
               base_in   = make_addr(wrap_state(dest_state), '0);
               reward_in = reward;
               if (func == FUNC_EPISODE) begin
                  prev_valid_in = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_td_in     = '0;
               end else if (!prev_valid_ff) begin
                  prev_valid_in  = 1'b1;
                  prev_state_in  = wrap_state(dest_state);
                  prev_action_in = wrap_action(dest_action);
                  rsp_valid_in   = 1'b1;
                  rsp_td_in      = '0;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CNT_ACTS) begin
               rd_addr = base_ff + cnt_ff[ADDR_W-1:0];
            end else begin
               rd_addr = prev_addr;
               cnt_in  = '0;
            end
         end
         ST_CALC: begin
            if (cnt_ff == CALC_PROD) prod_in = best_x * disc_x;
            if (cnt_ff == CALC_LAST) begin
               td_in  = sat32(diff);
               cnt_in = '0;
            end
         end
         ST_SWEEP: begin
            sweep_cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               prev_valid_in  = 1'b1;
               prev_state_in  = ns_ff;
               prev_action_in = na_ff;
               rsp_valid_in   = 1'b1;
               rsp_td_in      = td_ff;
            end
         end
         ST_WIPE: begin
            clr_trace_wr.we = 1'b1;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         prev_valid_ff <= 1'b0;
         rd_live_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         prev_valid_ff <= prev_valid_in;
         rd_live_ff    <= (state_ff == ST_SCAN);
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_state_ff  <= prev_state_in;
      prev_action_ff <= prev_action_in;
      ns_ff          <= ns_in;
      na_ff          <= na_in;
      base_ff        <= base_in;
      reward_ff      <= reward_in;
      best_ff        <= best_in;
      qprev_ff       <= qprev_in;
      prod_ff        <= prod_in;
      td_ff          <= td_in;
      rd_idx_ff      <= cnt_ff;
      rsp_td_ff      <= rsp_td_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_td    = rsp_td_ff;

endmodule

[hdl/tabular_q_lambda_update.sv]
// channel  | direction | handshake                        | payload
// ---------+-----------+----------------------------------+---------------------------------
// request  | in        | start high while busy low        | req_func, req_reward,
//          |           |                                  | req_dest_state, req_dest_action
// response | out       | rsp_valid, one cycle, no stall   | rsp_td_error
// config   | in        | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// An observe item with a previous pair runs a row scan through the value table read port,
// then one pass over every table entry through the four-stage trace and value update
// pipeline.
// An observe item without a previous pair answers in the next cycle and keeps busy low.
// An episode item answers in the next cycle and holds busy while the trace table
// is cleared; after reset both tables are cleared the same way.
// The response cannot be stalled; configuration writes are taken at any time.
module tabular_q_lambda_update (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_func,
   input  logic [31:0]                     req_reward,
   input  logic [tql_pkg::STATE_IN_W-1:0]  req_dest_state,
   input  logic [tql_pkg::ACT_IN_W-1:0]    req_dest_action,
   output logic                            rsp_valid,
   output logic [31:0]                     rsp_td_error,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [3:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import tql_pkg::*;

   logic [RATE_W-1:0]   discount_ff;
   logic [RATE_W-1:0]   decay_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic [VALUE_W-1:0]  baseline_ff;
   logic                csr_write;
   logic [ADDR_W-1:0]   rd_addr;
   logic [VALUE_W-1:0]  value_rd_data;
   logic [TRACE_W-1:0]  trace_rd_data;
   logic                pipe_busy;
   sweep_cmd_type       sweep_cmd;
   value_wr_type        clr_value_wr, sweep_value_wr, value_wr;
   trace_wr_type        clr_trace_wr, sweep_trace_wr, trace_wr;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         discount_ff <= 16'd62259;
         decay_ff    <= 16'd58982;
         rate_ff     <= 16'd6554;
         baseline_ff <= '0;
      end else if (csr_write) begin
         case (paddr[3:2])
            CSR_DISCOUNT:    discount_ff <= pwdata[RATE_W-1:0];
            CSR_TRACE_DECAY: decay_ff    <= pwdata[RATE_W-1:0];
            CSR_LEARN_RATE:  rate_ff     <= pwdata[RATE_W-1:0];
            CSR_BASELINE:    baseline_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (paddr[3:2])
         CSR_DISCOUNT:    prdata = {16'b0, discount_ff};
         CSR_TRACE_DECAY: prdata = {16'b0, decay_ff};
         CSR_LEARN_RATE:  prdata = {16'b0, rate_ff};
         CSR_BASELINE:    prdata = baseline_ff;
         default:         prdata = '0;
      endcase
   end

   // clearing writes take the port over from the update pipeline
   assign value_wr = clr_value_wr.we ? clr_value_wr : sweep_value_wr;
   assign trace_wr = clr_trace_wr.we ? clr_trace_wr : sweep_trace_wr;

   tql_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .func            (req_func),
      .reward          (req_reward),
      .dest_state      (req_dest_state),
      .dest_action     (req_dest_action),
      .discount        (discount_ff),
      .reward_baseline (baseline_ff),
      .value_rd_data   (value_rd_data),
      .pipe_busy       (pipe_busy),
      .rd_addr         (rd_addr),
      .sweep_cmd       (sweep_cmd),
      .clr_value_wr    (clr_value_wr),
      .clr_trace_wr    (clr_trace_wr),
      .rsp_valid       (rsp_valid),
      .rsp_td          (rsp_td_error)
   );

   tql_sweep u_sweep (
      .clock         (clock),
      .reset         (reset),
      .cmd           (sweep_cmd),
      .trace_decay   (decay_ff),
      .learning_rate (rate_ff),
      .trace_rd_data (trace_rd_data),
      .value_rd_data (value_rd_data),
      .trace_wr      (sweep_trace_wr),
      .value_wr      (sweep_value_wr),
      .pipe_busy     (pipe_busy)
   );

   tql_tables u_tables (
      .clock         (clock),
      .rd_addr       (rd_addr),
      .value_rd_data (value_rd_data),
      .trace_rd_data (trace_rd_data),
      .value_wr      (value_wr),
      .trace_wr      (trace_wr)
   );

endmodule

[tb/tabular_q_lambda_update_tb.sv]
module tabular_q_lambda_update_tb;
   import tql_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_WAIT  = 600;
   localparam int PHASE_ITEMS = 146;
   localparam int REWARD_MAX  = 32'h7FFF_FFFF;
   localparam int REWARD_MIN  = int'(32'h8000_0000);

   // Fixed-point model of the learner: value and trace tables, the last pair,
   // and the queue of TD errors still to come out of the block.
   class td_tracker;
      int                 q_value [TABLE_SIZE];
      bit [TRACE_W-1:0]   trace [TABLE_SIZE];
      bit [STATE_W-1:0]   last_state;
      bit [ACT_W-1:0]     last_action;
      bit                 have_last;
      bit [RATE_W-1:0]    gamma;
      bit [RATE_W-1:0]    lambda;
      bit [RATE_W-1:0]    alpha;
      int                 baseline;
      logic [31:0]        td_expected [$];
      int                 fails;

      function new();
         for (int i = 0; i < TABLE_SIZE; i++) begin
            q_value[i] = 0;
            trace[i]   = '0;
         end
         have_last = 1'b0;
         gamma     = 16'd62259;
         lambda    = 16'd58982;
         alpha     = 16'd6554;
         baseline  = 0;
         fails     = 0;
      endfunction

      function int clamp32(longint v);
         if (v > longint'(REWARD_MAX)) return REWARD_MAX;
         if (v < longint'(REWARD_MIN)) return REWARD_MIN;
         return int'(v);
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_DISCOUNT:    gamma    = data[RATE_W-1:0];
            CSR_TRACE_DECAY: lambda   = data[RATE_W-1:0];
            CSR_LEARN_RATE:  alpha    = data[RATE_W-1:0];
            CSR_BASELINE:    baseline = int'(data);
            default: ;
         endcase
      endfunction

      function int pending();
         return td_expected.size();
      endfunction

      // Apply one accepted item and queue the TD error it must produce
      function void take_item(logic func, int reward, logic [STATE_IN_W-1:0] ns,
                              logic [ACT_IN_W-1:0] na);
         int          s;
         int          a;
         int          best;
         int          td;
         int          p;
         longint      ret;
         longint      delta;
         bit [63:0]   step;
         if (func == FUNC_EPISODE) begin
            for (int i = 0; i < TABLE_SIZE; i++) trace[i] = '0;
            have_last = 1'b0;
            td_expected.push_back(32'd0);
            return;
         end
         s = int'(ns) % NUM_STATES;
         a = int'(na) % NUM_ACTIONS;
         // greedy value of the state just entered
         best = q_value[s * NUM_ACTIONS];
         for (int i = 1; i < NUM_ACTIONS; i++)
            if (q_value[s * NUM_ACTIONS + i] > best) best = q_value[s * NUM_ACTIONS + i];
         ret = longint'(reward) - longint'(baseline)
               + ((longint'(best) * longint'(gamma)) >>> 16);
         td = 0;
         if (have_last) begin
            p  = int'(last_state) * NUM_ACTIONS + int'(last_action);
            td = clamp32(ret - longint'(q_value[p]));
            // decay every trace, then refresh the previous pair
            for (int i = 0; i < TABLE_SIZE; i++)
               trace[i] = TRACE_W'((64'(trace[i]) * 64'(lambda)) >> 16);
            trace[p] = TRACE_ONE;
            for (int i = 0; i < TABLE_SIZE; i++) begin
               step       = (64'(trace[i]) * 64'(alpha)) >> 16;
               delta      = (longint'(step) * longint'(td)) >>> 16;
               q_value[i] = clamp32(longint'(q_value[i]) + delta);
            end
         end
         last_state  = STATE_W'(s);
         last_action = ACT_W'(a);
         have_last   = 1'b1;
         td_expected.push_back(32'(td));
      endfunction

      // Compare one response with the oldest outstanding TD error
      function void check_td(logic [31:0] got);
         logic [31:0] want;
         if (td_expected.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected response: td_error %h", got);
            return;
         end
         want = td_expected.pop_front();
         if (got !== want) begin
            fails++;
            if (fails <= 10) $display("td_error mismatch: expected %h, got %h", want, got);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_func;
   logic [31:0]            req_reward;
   logic [STATE_IN_W-1:0]  req_dest_state;
   logic [ACT_IN_W-1:0]    req_dest_action;
   logic                   rsp_valid;
   logic [31:0]            rsp_td_error;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [3:0]             paddr;
   logic [31:0]            pwdata;
   logic [31:0]            prdata;
   logic                   pready;

   td_tracker   tracker;
   int unsigned accepted = 0;
   int unsigned cycles = 0;

   tabular_q_lambda_update u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_reward      (req_reward),
      .req_dest_state  (req_dest_state),
      .req_dest_action (req_dest_action),
      .rsp_valid       (rsp_valid),
      .rsp_td_error    (rsp_td_error),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Note accepted items and check responses on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            tracker.take_item(req_func, int'(req_reward), req_dest_state, req_dest_action);
            accepted <= accepted + 1;
         end
         if (rsp_valid) tracker.check_td(rsp_td_error);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one item after an optional gap, hold it until it is taken
   task automatic send_item(logic func, int reward, logic [STATE_IN_W-1:0] ns,
                            logic [ACT_IN_W-1:0] na, int idle_pct);
      int          gap;
      int unsigned seen;
      gap = 0;
      while ($urandom_range(99, 0) < idle_pct && gap < 400) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func        <= func;
      req_reward      <= reward;
      req_dest_state  <= ns;
      req_dest_action <= na;
      start           <= 1'b1;
      seen = accepted;
      do @(negedge clock); while (accepted == seen);
   endtask

   // Random item: mostly observes of a few busy states, some noise
   task automatic random_item(int idle_pct);
      logic                   func;
      int                     reward;
      int                     sel;
      logic [STATE_IN_W-1:0]  ns;
      logic [ACT_IN_W-1:0]    na;
      func = ($urandom_range(99, 0) < 6) ? FUNC_EPISODE : FUNC_OBSERVE;
      sel  = $urandom_range(99, 0);
      if (sel < 60) begin
         reward = int'($urandom_range(32'h80000, 0)) - int'(32'h40000);
      end else if (sel < 85) begin
         reward = int'($urandom);
      end else begin
         case ($urandom_range(3, 0))
            0:       reward = REWARD_MAX;
            1:       reward = REWARD_MIN;
            2:       reward = 0;
            default: reward = -1;
         endcase
      end
      ns = ($urandom_range(9, 0) < 7) ? STATE_IN_W'($urandom_range(7, 0))
                                      : STATE_IN_W'($urandom_range(63, 0));
      na = ACT_IN_W'($urandom_range(7, 0));
      send_item(func, reward, ns, na, idle_pct);
   endtask

   // Stop sending and wait for every response and the end of any clearing pass
   task automatic settle();
      start <= 1'b0;
      while (tracker.pending() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.write_reg(idx, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_set(int g, int l, int a, int b);
      csr_write(CSR_DISCOUNT, 32'(g));
      csr_write(CSR_TRACE_DECAY, 32'(l));
      csr_write(CSR_LEARN_RATE, 32'(a));
      csr_write(CSR_BASELINE, 32'(b));
   endtask

   initial begin
      int idle_pct [5];
      int waited;
      tracker         = new();
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = FUNC_OBSERVE;
      req_reward      = '0;
      req_dest_state  = '0;
      req_dest_action = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      idle_pct        = '{0, 88, 20, 0, 88};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, first pair, reward extremes, index extremes
      send_item(FUNC_OBSERVE, 0, 6'd0, 3'd0, 0);
      send_item(FUNC_OBSERVE, REWARD_MAX, 6'd63, 3'd7, 0);
      send_item(FUNC_OBSERVE, REWARD_MIN, 6'd0, 3'd0, 0);
      send_item(FUNC_OBSERVE, 32'h0001_0000, 6'd63, 3'd7, 0);
      // new episode with junk fields, then an observe without a previous pair
      send_item(FUNC_EPISODE, -1, 6'd63, 3'd7, 0);
      send_item(FUNC_OBSERVE, 32'h0005_0000, 6'd1, 3'd3, 0);
      send_item(FUNC_OBSERVE, int'(32'hFFFD_8000), 6'd1, 3'd3, 0);
      send_item(FUNC_OBSERVE, 32'h0002_0000, 6'd42, 3'd5, 0);
      settle();

      // directed: full-scale rates, lowest baseline drives td and values to saturation
      csr_set(16'hFFFF, 16'hFFFF, 16'hFFFF, REWARD_MIN);
      repeat (3) send_item(FUNC_OBSERVE, REWARD_MAX, 6'd2, 3'd0, 0);
      repeat (3) send_item(FUNC_OBSERVE, REWARD_MIN, 6'd2, 3'd1, 0);
      settle();
      csr_write(CSR_BASELINE, 32'(REWARD_MAX));
      repeat (3) send_item(FUNC_OBSERVE, REWARD_MIN, 6'd3, 3'd6, 0);
      send_item(FUNC_EPISODE, REWARD_MAX, 6'd0, 3'd0, 0);
      send_item(FUNC_OBSERVE, 0, 6'd3, 3'd6, 0);
      settle();

      // random phases, each under its own settings and sender idling
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: csr_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_8000);
            1: csr_set(0, 0, 0, 0);
            2: csr_set($urandom_range(65535, 0), $urandom_range(65535, 0),
                       $urandom_range(65535, 0),
                       int'($urandom_range(32'h40000, 0)) - int'(32'h20000));
            3: csr_set(62259, 58982, 6554, 0);
            default: csr_set($urandom_range(65535, 0), $urandom_range(65535, 0),
                             $urandom_range(65535, 0), int'($urandom));
         endcase
         repeat (PHASE_ITEMS) random_item(idle_pct[p]);
         settle();
      end

      // drain and finish
      start <= 1'b0;
      waited = 0;
      while (tracker.pending() != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_WAIT) @(negedge clock);
      if (tracker.fails == 0 && tracker.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
